>>> rtl/voice_pool_allocator_defines.svh
// assertion macros for the voice pool allocator
`ifndef VOICE_POOL_ALLOCATOR_DEFINES_SVH
`define VOICE_POOL_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define VPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define VPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define VPA_ASSERT(lbl, prop, msg)
`define VPA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/vpa_pkg.sv
`default_nettype none

package vpa_pkg;

  localparam int VOICES  = 16;
  localparam int IDX_W   = $clog2(VOICES);
  localparam int CNT_W   = $clog2(VOICES + 1);
  localparam int VIDX_W  = (IDX_W > 4) ? IDX_W : 4;
  localparam int STAMP_W = 32;
  localparam int SOUND_W = 16;

  typedef enum logic [1:0] {
    OP_PLAY   = 2'd0,
    OP_FINISH = 2'd1,
    OP_STOP   = 2'd2,
    OP_COUNT  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  // partial result travelling down the row
  typedef struct packed {
    logic               idle_found;
    logic [IDX_W-1:0]   idle_idx;
    logic [STAMP_W-1:0] best_age;
    logic [IDX_W-1:0]   best_idx;
    logic [CNT_W-1:0]   count;
    logic               hit;
  } carry_t;

  // broadcast to every cell
  typedef struct packed {
    logic               upd;
    op_t                op;
    logic [IDX_W-1:0]   target;
    logic [VIDX_W-1:0]  vidx;
    logic [SOUND_W-1:0] sound;
    logic [STAMP_W-1:0] stamp;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic upd;
  } ctrl_t;

endpackage

`default_nettype wire

>>> rtl/vpa_cell.sv
`default_nettype none

module vpa_cell
  import vpa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,
  input  cmd_t             cmd,
  input  carry_t           carry_in,
  output carry_t           carry_out
);

  logic               active_r;
  logic [STAMP_W-1:0] stamp_r;
  logic [SOUND_W-1:0] sound_r;
  carry_t             carry_r;
  carry_t             carry_nxt;
  logic [STAMP_W-1:0] age;
  logic               own_vidx;
  logic               own_target;

  assign age        = cmd.stamp - stamp_r;
  assign own_vidx   = (VIDX_W'(cell_idx) == cmd.vidx);
  assign own_target = (cell_idx == cmd.target);

  always_comb begin
    carry_nxt = carry_in;
    if (!active_r) begin
      if (!carry_in.idle_found) begin
        carry_nxt.idle_found = 1'b1;
        carry_nxt.idle_idx   = cell_idx;
      end
    end else begin
      carry_nxt.count = carry_in.count + CNT_W'(1);
    end
    if (age > carry_in.best_age) begin
      carry_nxt.best_age = age;
      carry_nxt.best_idx = cell_idx;
    end
    if (active_r && own_vidx) begin
      carry_nxt.hit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    carry_r <= carry_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      stamp_r  <= '0;
    end else if (cmd.upd) begin
      unique case (cmd.op)
        OP_PLAY: begin
          if (own_target) begin
            active_r <= 1'b1;
            stamp_r  <= cmd.stamp;
          end
        end
        OP_FINISH: begin
          if (own_vidx) begin
            active_r <= 1'b0;
          end
        end
        OP_STOP:  active_r <= 1'b0;
        OP_COUNT: active_r <= active_r;
        default:  active_r <= active_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd && cmd.op == OP_PLAY && own_target) begin
      sound_r <= cmd.sound;
    end
  end

  assign carry_out = carry_r;

endmodule

`default_nettype wire

>>> rtl/vpa_ctrl.sv
`default_nettype none

module vpa_ctrl
  import vpa_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output ctrl_t ctrl
);

  state_t           state_r;
  state_t           state_nxt;
  logic [IDX_W-1:0] cnt_r;
  logic [IDX_W-1:0] cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (start) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + IDX_W'(1);
        if (cnt_r == IDX_W'(VOICES - 1)) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.busy = (state_r != ST_IDLE);
    ctrl.upd  = (state_r == ST_UPDATE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/voice_pool_allocator.sv
// Voice pool allocator: hands out playback voices from a pool of VOICES.
// Command channel: present in_operation, in_voice_index and in_sound_id with
// start high; the item is taken on the edge where start is high and busy is
// low. Operations: play request, voice finished, stop all, count query.
// Result channel: out_valid is high for exactly one cycle with
// out_chosen_voice, out_stolen and out_playing_count; the receiver cannot
// hold it off and must take it in that cycle.
// Sequence: after the accepting edge the controller runs its scan state
// and then its update state; out_valid is registered from the update
// state. No new item is taken before the last one is done, and busy is
// already low while the strobe is shown. A search record walks the row
// of voice cells one cell per cycle, collecting the first idle voice, the
// oldest stamp and the playing count; the update writes the chosen cell.
// Reset (rst_n low, synchronous) marks every voice idle, clears the stamps
// and the stamp counter, and drops busy and out_valid.
`default_nettype none
`include "voice_pool_allocator_defines.svh"

module voice_pool_allocator
  import vpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [3:0]  in_voice_index,
  input  logic [15:0] in_sound_id,
  output logic        out_valid,
  output logic [3:0]  out_chosen_voice,
  output logic        out_stolen,
  output logic [4:0]  out_playing_count
);

  ctrl_t              ctrl;
  logic               accept;
  op_t                op_r;
  logic [VIDX_W-1:0]  vidx_r;
  logic [SOUND_W-1:0] sound_r;
  logic [STAMP_W-1:0] next_stamp_r;
  cmd_t               cmd;
  carry_t             chain [VOICES+1];
  carry_t             last;
  logic [IDX_W-1:0]   target;
  logic               out_valid_r;
  logic [3:0]         chosen_r;
  logic               stolen_r;
  logic [4:0]         count_r;
  logic [CNT_W-1:0]   count_nxt;

  assign accept = start && !ctrl.busy;

  vpa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .ctrl  (ctrl)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= op_t'(in_operation);
      vidx_r  <= VIDX_W'(in_voice_index);
      sound_r <= in_sound_id;
    end
  end

  assign last   = chain[VOICES];
  assign target = last.idle_found ? last.idle_idx : last.best_idx;

  always_comb begin
    cmd.upd    = ctrl.upd;
    cmd.op     = op_r;
    cmd.target = target;
    cmd.vidx   = vidx_r;
    cmd.sound  = sound_r;
    cmd.stamp  = next_stamp_r;
  end

  assign chain[0] = '0;

  for (genvar g = 0; g < VOICES; g++) begin : g_cell
    vpa_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (IDX_W'(g)),
      .cmd       (cmd),
      .carry_in  (chain[g]),
      .carry_out (chain[g+1])
    );
  end

  always_comb begin
    unique case (op_r)
      OP_PLAY:   count_nxt = last.idle_found ? last.count + CNT_W'(1) : last.count;
      OP_FINISH: count_nxt = last.count - CNT_W'(last.hit);
      OP_STOP:   count_nxt = '0;
      OP_COUNT:  count_nxt = last.count;
      default:   count_nxt = last.count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      next_stamp_r <= '0;
    end else begin
      out_valid_r <= ctrl.upd;
      if (ctrl.upd && op_r == OP_PLAY) begin
        next_stamp_r <= next_stamp_r + STAMP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.upd) begin
      chosen_r <= (op_r == OP_PLAY) ? 4'(target) : 4'd0;
      stolen_r <= (op_r == OP_PLAY) && !last.idle_found;
      count_r  <= 5'(count_nxt);
    end
  end

  assign busy              = ctrl.busy;
  assign out_valid         = out_valid_r;
  assign out_chosen_voice  = chosen_r;
  assign out_stolen        = out_valid_r & stolen_r;
  assign out_playing_count = count_r;

  // assertions
  `VPA_ASSERT(a_strobe_idle, out_valid |-> !busy, "result shown while still busy")
  `VPA_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "strobe longer than one cycle")
  `VPA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `VPA_ASSERT(a_steal_full, out_stolen |-> out_playing_count == 5'(VOICES), "steal with pool not full")

endmodule

`default_nettype wire
